// ===== hw/rtl/ltmm_pkg.sv =====
// ltmm_pkg: shared widths, register indexes, config and queue item types, click tables
// used by every module of the loop transport metronome master; no dependencies
package ltmm_pkg;

	localparam int FRAME_W     = 24;
	localparam int FRAME_IDX_W = $clog2(FRAME_W);
	localparam int SAMPLE_W    = 24;
	localparam int PEAK_W      = SAMPLE_W - 1;
	localparam int GAIN_W      = 16;
	localparam int BEAT_W      = 8;
	localparam int OPT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int CLICK_LEN   = 38;
	localparam int CLICK_SRC   = 38;
	localparam int CLICK_TAB   = 64;
	localparam int POS_W       = $clog2(CLICK_TAB);
	localparam int CLICK_W     = SAMPLE_W;
	localparam int CLICK_SUM_W = CLICK_W + 1;
	localparam int BASE_W      = CLICK_SUM_W + 1;

	localparam int MUL_A_W     = BASE_W + 2;
	localparam int MUL_B_W     = GAIN_W + 1;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int GAIN_SHIFT  = 14;
	localparam int RND_W       = PROD_W - GAIN_SHIFT;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// option bit positions
	localparam int OPT_METRO   = 0;
	localparam int OPT_MONITOR = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS  = 3'd6;

	localparam logic [FRAME_W-1:0] LOOP_RST    = 24'd192000;
	localparam logic [FRAME_W-1:0] BAR_RST     = 24'd192000;
	localparam logic [FRAME_W-1:0] BEAT_RST    = 24'd48000;
	localparam logic [FRAME_W-1:0] QUANTUM_RST = 24'd0;
	localparam logic [GAIN_W-1:0]  GAIN_RST    = 16'd16384;
	localparam logic [OPT_W-1:0]   OPT_RST     = 3'd0;

	typedef struct packed {
		logic [FRAME_W-1:0] loop_frames;
		logic [FRAME_W-1:0] bar_frames;
		logic [FRAME_W-1:0] beat_frames;
		logic [FRAME_W-1:0] quantum_frames;
		logic [GAIN_W-1:0]  out_gain;
		logic [GAIN_W-1:0]  in_gain;
		logic [OPT_W-1:0]   options;
	} cfg_t;

	// one classified frame, passed from front to back
	typedef struct packed {
		logic signed [BASE_W-1:0]   base_l;
		logic signed [BASE_W-1:0]   base_r;
		logic signed [SAMPLE_W-1:0] line_l;
		logic signed [SAMPLE_W-1:0] line_r;
		logic                       bstart;
		logic                       qp;
		logic                       bp;
		logic                       lz;
		logic [BEAT_W-1:0]          beat;
		logic [FRAME_W-1:0]         frame;
	} fe_item_t;

	typedef enum logic [0:0] {
		FR_RUN,
		FR_SYNC
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL_LL,
		BK_MUL_LR,
		BK_MUL_SL,
		BK_MUL_SR
	} bk_state_t;

	// click shapes in millionths of full scale
	localparam int TOCK_MICRO [CLICK_SRC] = '{
		59033, 117240, 173807, 227943, 278890, 325936,
		368423, 405755, 437413, 462951, 482013, 494333,
		499738, 498153, 489598, 474195, 452159, 423798,
		389509, 349771, 289883, 230617, 173194, 118739,
		68260, 22631, -17423, -51339, -78721, -99345,
		-113163, -120295, -121028, -115804, -105209, -89954,
		-70862, -48844
	};

	localparam int TICK_MICRO [CLICK_SRC] = '{
		175860, 341914, 488904, 608633, 694426, 741500,
		747229, 711293, 635697, 524656, 384362, 222636,
		48496, -128348, -298035, -451105, -579021, -674653,
		-732667, -749830, -688924, -594091, -474481, -340160,
		-201360, -67752, 52194, 151746, 226280, 273493,
		293425, 288307, 262252, 220811, 170435, 117887,
		69639, 31320
	};

	typedef logic signed [CLICK_W-1:0] click_tab_t [CLICK_TAB];

	// q1.23 table, halves rounded away from zero, zero past the shape
	function automatic click_tab_t click_table(input bit is_tick);
		click_tab_t t;
		longint     u;
		for (int i = 0; i < CLICK_TAB; i++) begin
			if (i < CLICK_SRC) begin
				u = is_tick ? longint'(TICK_MICRO[i]) : longint'(TOCK_MICRO[i]);
			end else begin
				u = 0;
			end
			t[i] = CLICK_W'((u * 64'sd8388608 + ((u < 0) ? -64'sd500000 : 64'sd500000))
				/ 64'sd1000000);
		end
		return t;
	endfunction

	localparam click_tab_t TOCK_TAB = click_table(1'b0);
	localparam click_tab_t TICK_TAB = click_table(1'b1);

endpackage

// ===== hw/rtl/loop_transport_metronome_master_top.sv =====
// loop_transport_metronome_master_top: items pass the queue, gain steps and output register
// the single multiplier does 4 products per item; the next item is popped with the last one
// writes to bar, beat or quantize registers start a phase recompute, in_ready low
// reset clears counters, beat, rewind, clicks and peaks, and loads default registers
// depends on ltmm_pkg, ltmm_front, ltmm_fifo, ltmm_back
module loop_transport_metronome_master_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [ltmm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ltmm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0]  program_left,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0]  program_right,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0]  line_left,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0]  line_right,
	input  logic                                  transport_run,
	input  logic                                  rewind_request,
	input  logic                                  buffer_start,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ltmm_pkg::SAMPLE_W-1:0]  out_left,
	output logic signed [ltmm_pkg::SAMPLE_W-1:0]  out_right,
	output logic [ltmm_pkg::PEAK_W-1:0]           peak_out,
	output logic [ltmm_pkg::PEAK_W-1:0]           peak_in,
	output logic                                  quantum_point,
	output logic                                  bar_point,
	output logic                                  loop_zero,
	output logic [ltmm_pkg::BEAT_W-1:0]           beat_index,
	output logic [ltmm_pkg::FRAME_W-1:0]          frame_position
);
	import ltmm_pkg::*;

	cfg_t     cfg_q;
	logic     resync, push, pop, q_full, q_empty;
	fe_item_t push_item, pop_item;

	assign resync = cfg_write && (cfg_index == CFG_BAR || cfg_index == CFG_BEAT ||
		cfg_index == CFG_QUANTUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_frames    <= LOOP_RST;
			cfg_q.bar_frames     <= BAR_RST;
			cfg_q.beat_frames    <= BEAT_RST;
			cfg_q.quantum_frames <= QUANTUM_RST;
			cfg_q.out_gain       <= GAIN_RST;
			cfg_q.in_gain        <= GAIN_RST;
			cfg_q.options        <= OPT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LOOP:     cfg_q.loop_frames    <= cfg_data[FRAME_W-1:0];
				CFG_BAR:      cfg_q.bar_frames     <= cfg_data[FRAME_W-1:0];
				CFG_BEAT:     cfg_q.beat_frames    <= cfg_data[FRAME_W-1:0];
				CFG_QUANTUM:  cfg_q.quantum_frames <= cfg_data[FRAME_W-1:0];
				CFG_OUT_GAIN: cfg_q.out_gain       <= cfg_data[GAIN_W-1:0];
				CFG_IN_GAIN:  cfg_q.in_gain        <= cfg_data[GAIN_W-1:0];
				CFG_OPTIONS:  cfg_q.options        <= cfg_data[OPT_W-1:0];
				default: ;
			endcase
		end
	end

	ltmm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.resync         (resync),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.program_left   (program_left),
		.program_right  (program_right),
		.line_left      (line_left),
		.line_right     (line_right),
		.transport_run  (transport_run),
		.rewind_request (rewind_request),
		.buffer_start   (buffer_start),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	ltmm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	ltmm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_item         (pop_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_left       (out_left),
		.out_right      (out_right),
		.peak_out       (peak_out),
		.peak_in        (peak_in),
		.quantum_point  (quantum_point),
		.bar_point      (bar_point),
		.loop_zero      (loop_zero),
		.beat_index     (beat_index),
		.frame_position (frame_position)
	);

endmodule

// ===== hw/rtl/ltmm_front.sv =====
// ltmm_front: accepts frames, runs the loop transport, beat count and click players
// keeps grid phases in step with the counter; depends on ltmm_pkg
module ltmm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ltmm_pkg::cfg_t                      cfg,
	input  logic                                resync,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0] program_left,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0] program_right,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0] line_left,
	input  logic signed [ltmm_pkg::SAMPLE_W-1:0] line_right,
	input  logic                                transport_run,
	input  logic                                rewind_request,
	input  logic                                buffer_start,
	input  logic                                q_full,
	output logic                                push,
	output ltmm_pkg::fe_item_t                  push_item
);
	import ltmm_pkg::*;

	localparam logic [1:0] PH_QUANT = 2'd0;
	localparam logic [1:0] PH_BAR   = 2'd1;
	localparam logic [1:0] PH_BEAT  = 2'd2;

	fr_state_t                state_q, state_d;
	logic [FRAME_W-1:0]       frame_q;
	logic [BEAT_W-1:0]        beat_q;
	logic                     rew_q, tick_act_q, tock_act_q;
	logic [POS_W-1:0]         tick_pos_q, tock_pos_q;
	logic [FRAME_W-1:0]       qph_q, bph_q, tph_q;
	logic [1:0]               sel_q;
	logic [FRAME_IDX_W-1:0]   bit_q;
	logic [FRAME_W-1:0]       rem_q, rem_d;
	logic [FRAME_W:0]         rem_shift;
	logic [FRAME_W-1:0]       sync_per;

	logic [FRAME_W-1:0]       f_d, pq_d, pb_d, pt_d;
	logic [FRAME_W:0]         nxt;
	logic [BEAT_W-1:0]        bt_d;
	logic                     rw_d, tka_d, tca_d, qp, bp, lz, metro;
	logic [POS_W-1:0]         tkp_d, tcp_d, tkn, tcn;
	logic signed [CLICK_SUM_W-1:0] click;

	function automatic logic [FRAME_W-1:0] ph_adv(input logic [FRAME_W-1:0] ph,
		input logic [FRAME_W-1:0] per);
		logic [FRAME_W:0] s;
		s = {1'b0, ph} + (FRAME_W+1)'(1);
		if (per == '0 || s == {1'b0, per}) begin
			return '0;
		end
		return s[FRAME_W-1:0];
	endfunction

	// sync control and handshake
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_RUN: begin
				if (resync) state_d = FR_SYNC;
			end
			FR_SYNC: begin
				if (!resync && sel_q == PH_BEAT && bit_q == '0) state_d = FR_RUN;
			end
			default: state_d = FR_RUN;
		endcase
		in_ready = (state_q == FR_RUN) && !q_full;
		push     = in_valid && in_ready;
	end

	// restoring remainder, one counter bit a cycle
	always_comb begin
		case (sel_q)
			PH_QUANT: sync_per = cfg.quantum_frames;
			PH_BAR:   sync_per = cfg.bar_frames;
			default:  sync_per = cfg.beat_frames;
		endcase
		rem_shift = {rem_q, frame_q[bit_q]};
		if (rem_shift >= {1'b0, sync_per}) begin
			rem_d = FRAME_W'(rem_shift - {1'b0, sync_per});
		end else begin
			rem_d = rem_shift[FRAME_W-1:0];
		end
	end

	// one transport step
	always_comb begin
		metro = cfg.options[OPT_METRO];
		f_d   = frame_q;
		bt_d  = beat_q;
		rw_d  = rew_q | rewind_request;
		tka_d = tick_act_q;
		tca_d = tock_act_q;
		tkp_d = tick_pos_q;
		tcp_d = tock_pos_q;
		pq_d  = qph_q;
		pb_d  = bph_q;
		pt_d  = tph_q;
		qp    = 1'b0;
		bp    = 1'b0;
		lz    = 1'b0;
		nxt   = '0;
		tkn   = '0;
		tcn   = '0;
		click = '0;
		if (transport_run) begin
			if (cfg.quantum_frames != '0 && pq_d == '0) begin
				qp = 1'b1;
				if (rw_d) begin
					rw_d = 1'b0;
					f_d  = '0;
					bt_d = '0;
					pb_d = '0;
					pt_d = '0;
				end
			end
			if (cfg.bar_frames != '0 && f_d != '0 && pb_d == '0) begin
				bp = 1'b1;
				if (metro) tka_d = 1'b1;
			end
			lz  = (f_d == '0);
			nxt = {1'b0, f_d} + (FRAME_W+1)'(1);
			if (nxt > {1'b0, cfg.loop_frames}) begin
				f_d  = '0;
				bt_d = '0;
				pq_d = '0;
				pb_d = '0;
				pt_d = '0;
			end else begin
				f_d  = nxt[FRAME_W-1:0];
				pq_d = ph_adv(pq_d, cfg.quantum_frames);
				pb_d = ph_adv(pb_d, cfg.bar_frames);
				pt_d = ph_adv(pt_d, cfg.beat_frames);
				if (cfg.beat_frames != '0 && pt_d == '0) begin
					if (bt_d != {BEAT_W{1'b1}}) bt_d = bt_d + 1'b1;
					if (metro && !tka_d) tca_d = 1'b1;
				end
			end
		end
		if (tca_d) begin
			click = click + CLICK_SUM_W'(TOCK_TAB[tcp_d]);
			tcn   = tcp_d + POS_W'(1);
			if (tcn >= POS_W'(CLICK_LEN - 1)) begin
				tca_d = 1'b0;
				tcp_d = '0;
			end else begin
				tcp_d = tcn;
			end
		end
		if (tka_d) begin
			click = click + CLICK_SUM_W'(TICK_TAB[tkp_d]);
			tkn   = tkp_d + POS_W'(1);
			if (tkn >= POS_W'(CLICK_LEN - 1)) begin
				tka_d = 1'b0;
				tkp_d = '0;
			end else begin
				tkp_d = tkn;
			end
		end
	end

	always_comb begin
		push_item.base_l = BASE_W'(program_left) + BASE_W'(click);
		push_item.base_r = BASE_W'(program_right) + BASE_W'(click);
		push_item.line_l = line_left;
		push_item.line_r = line_right;
		push_item.bstart = buffer_start;
		push_item.qp     = qp;
		push_item.bp     = bp;
		push_item.lz     = lz;
		push_item.beat   = bt_d;
		push_item.frame  = f_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_RUN;
			frame_q    <= '0;
			beat_q     <= '0;
			rew_q      <= 1'b0;
			tick_act_q <= 1'b0;
			tock_act_q <= 1'b0;
			tick_pos_q <= '0;
			tock_pos_q <= '0;
			qph_q      <= '0;
			bph_q      <= '0;
			tph_q      <= '0;
			sel_q      <= '0;
			bit_q      <= '0;
			rem_q      <= '0;
		end else begin
			state_q <= state_d;
			if (resync) begin
				sel_q <= PH_QUANT;
				bit_q <= FRAME_IDX_W'(FRAME_W - 1);
				rem_q <= '0;
			end else if (state_q == FR_SYNC) begin
				if (bit_q == '0) begin
					case (sel_q)
						PH_QUANT: qph_q <= rem_d;
						PH_BAR:   bph_q <= rem_d;
						default:  tph_q <= rem_d;
					endcase
					rem_q <= '0;
					bit_q <= FRAME_IDX_W'(FRAME_W - 1);
					sel_q <= sel_q + 1'b1;
				end else begin
					rem_q <= rem_d;
					bit_q <= bit_q - 1'b1;
				end
			end
			if (push) begin
				frame_q    <= f_d;
				beat_q     <= bt_d;
				rew_q      <= rw_d;
				tick_act_q <= tka_d;
				tock_act_q <= tca_d;
				tick_pos_q <= tkp_d;
				tock_pos_q <= tcp_d;
				qph_q      <= pq_d;
				bph_q      <= pb_d;
				tph_q      <= pt_d;
			end
		end
	end

	a_bar_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FR_RUN && cfg.bar_frames != '0) |-> (bph_q < cfg.bar_frames))
		else $error("bar phase out of range");

	a_beat_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FR_RUN && cfg.beat_frames != '0) |-> (tph_q < cfg.beat_frames))
		else $error("beat phase out of range");

	a_quant_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FR_RUN && cfg.quantum_frames != '0) |-> (qph_q < cfg.quantum_frames))
		else $error("quantize phase out of range");

endmodule

// ===== hw/rtl/ltmm_fifo.sv =====
// ltmm_fifo: short item queue between front and back
// depends on ltmm_pkg for the item type and depth
module ltmm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ltmm_pkg::fe_item_t push_item,
	input  logic               pop,
	output ltmm_pkg::fe_item_t pop_item,
	output logic               full,
	output logic               empty
);
	import ltmm_pkg::*;

	fe_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

endmodule

// ===== hw/rtl/ltmm_back.sv =====
// ltmm_back: gain stage on one shared multiplier, peaks, saturation, output register
// depends on ltmm_pkg
module ltmm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ltmm_pkg::cfg_t                       cfg,
	input  logic                                 q_empty,
	input  ltmm_pkg::fe_item_t                   q_item,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ltmm_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [ltmm_pkg::SAMPLE_W-1:0] out_right,
	output logic [ltmm_pkg::PEAK_W-1:0]          peak_out,
	output logic [ltmm_pkg::PEAK_W-1:0]          peak_in,
	output logic                                 quantum_point,
	output logic                                 bar_point,
	output logic                                 loop_zero,
	output logic [ltmm_pkg::BEAT_W-1:0]          beat_index,
	output logic [ltmm_pkg::FRAME_W-1:0]         frame_position
);
	import ltmm_pkg::*;

	bk_state_t                 state_q, state_d;
	fe_item_t                  it_q;
	logic signed [PROD_W-1:0]  prod_q, prod_d;
	logic signed [MUL_A_W-1:0] mul_a, sum_l_q, sum_r_q;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [RND_W-1:0]   rnd_v, gain_v, sl_q;
	logic [PEAK_W-1:0]         peak_in_q, peak_out_q, pin_base, pout_base;
	logic                      fin_q, out_free, stall, mon;
	logic                      qp_q, bp_q, lz_q;
	logic [BEAT_W-1:0]         beat_q;
	logic [FRAME_W-1:0]        frame_q;

	// floor((x + 2^13) / 2^14)
	function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] t;
		t = x + $signed(PROD_W'(1) << (GAIN_SHIFT - 1));
		return $signed(t[PROD_W-1:GAIN_SHIFT]);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] hi, lo;
		hi = $signed({{(RND_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}});
		lo = $signed({{(RND_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}});
		if (v > hi) return hi[SAMPLE_W-1:0];
		if (v < lo) return lo[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [PEAK_W-1:0] peak_upd(input logic signed [RND_W-1:0] v,
		input logic [PEAK_W-1:0] base);
		logic signed [RND_W-1:0] b, mx;
		b  = $signed({{(RND_W-PEAK_W){1'b0}}, base});
		mx = $signed({{(RND_W-PEAK_W){1'b0}}, {PEAK_W{1'b1}}});
		if (v <= b) return base;
		if (v > mx) return {PEAK_W{1'b1}};
		return v[PEAK_W-1:0];
	endfunction

	assign out_free  = !out_valid || out_ready;
	assign stall     = fin_q && !out_free;
	assign mon       = cfg.options[OPT_MONITOR];
	assign rnd_v     = rnd(prod_q);
	assign gain_v    = mon ? rnd_v : '0;
	assign pin_base  = it_q.bstart ? '0 : peak_in_q;
	assign pout_base = it_q.bstart ? '0 : peak_out_q;
	assign prod_d    = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			BK_IDLE: begin
				if (!stall && !q_empty) begin
					pop     = 1'b1;
					state_d = BK_MUL_LL;
				end
			end
			BK_MUL_LL: begin
				mul_a = MUL_A_W'(it_q.line_l);
				mul_b = $signed({1'b0, cfg.in_gain});
				if (!stall) state_d = BK_MUL_LR;
			end
			BK_MUL_LR: begin
				mul_a   = MUL_A_W'(it_q.line_r);
				mul_b   = $signed({1'b0, cfg.in_gain});
				state_d = BK_MUL_SL;
			end
			BK_MUL_SL: begin
				mul_a   = sum_l_q;
				mul_b   = $signed({1'b0, cfg.out_gain});
				state_d = BK_MUL_SR;
			end
			BK_MUL_SR: begin
				mul_a = sum_r_q;
				mul_b = $signed({1'b0, cfg.out_gain});
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = BK_MUL_LL;
				end else begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			fin_q      <= 1'b0;
			out_valid  <= 1'b0;
			peak_in_q  <= '0;
			peak_out_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_MUL_LR) begin
				peak_in_q <= peak_upd(gain_v, pin_base);
			end
			if (state_q == BK_MUL_SR) begin
				peak_out_q <= peak_upd(rnd_v, pout_base);
				fin_q      <= 1'b1;
			end else if (fin_q && out_free) begin
				fin_q <= 1'b0;
			end
			if (fin_q && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) it_q <= q_item;
		if (state_q != BK_IDLE && !stall) prod_q <= prod_d;
		case (state_q)
			BK_MUL_LR: sum_l_q <= MUL_A_W'(it_q.base_l) + $signed(gain_v[MUL_A_W-1:0]);
			BK_MUL_SL: sum_r_q <= MUL_A_W'(it_q.base_r) + $signed(gain_v[MUL_A_W-1:0]);
			BK_MUL_SR: begin
				sl_q    <= rnd_v;
				qp_q    <= it_q.qp;
				bp_q    <= it_q.bp;
				lz_q    <= it_q.lz;
				beat_q  <= it_q.beat;
				frame_q <= it_q.frame;
			end
			default: ;
		endcase
		if (fin_q && out_free) begin
			out_left       <= sat(sl_q);
			out_right      <= sat(rnd_v);
			peak_out       <= peak_out_q;
			peak_in        <= peak_in_q;
			quantum_point  <= qp_q;
			bar_point      <= bp_q;
			loop_zero      <= lz_q;
			beat_index     <= beat_q;
			frame_position <= frame_q;
		end
	end

	// a finished item waits only while the next one is loading or starting
	a_fin_state: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (state_q == BK_IDLE || state_q == BK_MUL_LL))
		else $error("finished item pending outside first step");

endmodule

// ===== bench/loop_transport_metronome_master_top_tb.sv =====
// loop_transport_metronome_master_top_tb: self-checking bench for the loop transport master
// drives frames and register writes, predicts every output item and compares field by field
// depends on ltmm_pkg and loop_transport_metronome_master_top
`timescale 1ns / 100ps

module loop_transport_metronome_master_top_tb;
	import ltmm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SHAPE_LEN   = 38;
	localparam int PRINT_CAP   = 100;
	localparam longint FRAME_TOP = 16777214;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct {
		logic signed [SAMPLE_W-1:0] pl;
		logic signed [SAMPLE_W-1:0] pr;
		logic signed [SAMPLE_W-1:0] ll;
		logic signed [SAMPLE_W-1:0] lr;
		bit                         run;
		bit                         rew;
		bit                         bst;
	} frame_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [PEAK_W-1:0]          pk_out;
		logic [PEAK_W-1:0]          pk_in;
		bit                         qp;
		bit                         bp;
		bit                         lz;
		logic [BEAT_W-1:0]          beat;
		logic [FRAME_W-1:0]         pos;
	} mix_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] program_left = '0;
	logic signed [SAMPLE_W-1:0] program_right = '0;
	logic signed [SAMPLE_W-1:0] line_left = '0;
	logic signed [SAMPLE_W-1:0] line_right = '0;
	logic                       transport_run = 1'b0;
	logic                       rewind_request = 1'b0;
	logic                       buffer_start = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic [PEAK_W-1:0]          peak_out;
	logic [PEAK_W-1:0]          peak_in;
	logic                       quantum_point;
	logic                       bar_point;
	logic                       loop_zero;
	logic [BEAT_W-1:0]          beat_index;
	logic [FRAME_W-1:0]         frame_position;

	// click shapes in millionths of full scale
	int tock_um [0:SHAPE_LEN-1] = '{
		59033, 117240, 173807, 227943, 278890, 325936,
		368423, 405755, 437413, 462951, 482013, 494333,
		499738, 498153, 489598, 474195, 452159, 423798,
		389509, 349771, 289883, 230617, 173194, 118739,
		68260, 22631, -17423, -51339, -78721, -99345,
		-113163, -120295, -121028, -115804, -105209, -89954,
		-70862, -48844
	};
	int tick_um [0:SHAPE_LEN-1] = '{
		175860, 341914, 488904, 608633, 694426, 741500,
		747229, 711293, 635697, 524656, 384362, 222636,
		48496, -128348, -298035, -451105, -579021, -674653,
		-732667, -749830, -688924, -594091, -474481, -340160,
		-201360, -67752, 52194, 151746, 226280, 273493,
		293425, 288307, 262252, 220811, 170435, 117887,
		69639, 31320
	};

	// predictor registers and state
	longint     loop_r = 192000, bar_r = 192000, beat_r = 48000, quant_r = 0;
	longint     og_r = 16384, ig_r = 16384;
	logic [2:0] opt_r = '0;
	longint     fc = 0, bc = 0;
	bit         rew_pend = 0, tick_on = 0, tock_on = 0;
	int         tick_ph = 0, tock_ph = 0;
	longint     pk_out_r = 0, pk_in_r = 0;

	frame_t frame_queue [$];
	mix_t   due_outputs [$];
	frame_t cur_frame;
	bit     item_taken = 0;
	bit     calm = 1;
	bit     hold_done = 0;
	int     send_gap = 0, ready_gap = 0, hold_left = 0;
	int     sent_total = 0, taken_total = 0, results_seen = 0;
	int     fails = 0, cycles = 0;

	loop_transport_metronome_master_top i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("loop_transport_metronome_master_top regression: fail");
			$finish;
		end
	end

	function automatic longint q14_round(longint x);
		return (x + 8192) >>> 14;
	endfunction

	function automatic longint clip_sample(longint x);
		longint hi;
		hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
		return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
	endfunction

	function automatic longint cap_peak(longint x);
		longint hi;
		hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
		return x > hi ? hi : x;
	endfunction

	function automatic longint click_q(bit tick, int idx);
		longint u;
		if (idx >= SHAPE_LEN)
			return 0;
		u = tick ? tick_um[idx] : tock_um[idx];
		return (u * 8388608 + (u < 0 ? -500000 : 500000)) / 1000000;
	endfunction

	function automatic mix_t master_step(frame_t f);
		mix_t   r;
		longint gl, gr, click, sl, sr, nxt;
		bit     metro;
		metro = opt_r[OPT_METRO];
		r.qp = 0;
		r.bp = 0;
		r.lz = 0;
		gl = 0;
		gr = 0;
		click = 0;
		if (f.bst) begin
			pk_out_r = 0;
			pk_in_r = 0;
		end
		if (f.rew)
			rew_pend = 1;
		if (opt_r[OPT_MONITOR]) begin
			gl = q14_round(longint'(f.ll) * ig_r);
			gr = q14_round(longint'(f.lr) * ig_r);
			if (gl > pk_in_r)
				pk_in_r = cap_peak(gl);
		end
		if (f.run) begin
			if (quant_r != 0 && fc % quant_r == 0) begin
				r.qp = 1;
				if (rew_pend) begin
					rew_pend = 0;
					fc = 0;
					bc = 0;
				end
			end
			if (bar_r != 0 && fc != 0 && fc % bar_r == 0) begin
				r.bp = 1;
				if (metro)
					tick_on = 1;
			end
			r.lz = (fc == 0);
			nxt = fc + 1;
			if (nxt > loop_r || nxt > 64'hFFFFFF) begin
				fc = 0;
				bc = 0;
			end else begin
				fc = nxt;
				if (beat_r != 0 && nxt % beat_r == 0) begin
					if (bc < 255)
						bc++;
					if (metro && !tick_on)
						tock_on = 1;
				end
			end
		end
		if (tock_on) begin
			click += click_q(1'b0, tock_ph);
			tock_ph = (tock_ph + 1) & (CLICK_TAB - 1);
			if (tock_ph >= CLICK_LEN - 1) begin
				tock_on = 0;
				tock_ph = 0;
			end
		end
		if (tick_on) begin
			click += click_q(1'b1, tick_ph);
			tick_ph = (tick_ph + 1) & (CLICK_TAB - 1);
			if (tick_ph >= CLICK_LEN - 1) begin
				tick_on = 0;
				tick_ph = 0;
			end
		end
		sl = q14_round((longint'(f.pl) + click + gl) * og_r);
		sr = q14_round((longint'(f.pr) + click + gr) * og_r);
		if (sl > pk_out_r)
			pk_out_r = cap_peak(sl);
		r.left = SAMPLE_W'(clip_sample(sl));
		r.right = SAMPLE_W'(clip_sample(sr));
		r.pk_out = PEAK_W'(pk_out_r);
		r.pk_in = PEAK_W'(pk_in_r);
		r.beat = BEAT_W'(bc);
		r.pos = FRAME_W'(fc);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic longint pick_gain();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65535;
			2: return 16384;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic longint pick_span(int lo, int hi);
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(lo, hi);
		return FRAME_TOP;
	endfunction

	function automatic frame_t frame_of(logic signed [SAMPLE_W-1:0] pl, pr, ll, lr,
		bit run, bit rew, bit bst);
		frame_t f;
		f.pl = pl;
		f.pr = pr;
		f.ll = ll;
		f.lr = lr;
		f.run = run;
		f.rew = rew;
		f.bst = bst;
		return f;
	endfunction

	function automatic frame_t random_frame(bit steady);
		return frame_of(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
			steady || ($urandom_range(0, 9) != 0), $urandom_range(0, 19) == 0,
			$urandom_range(0, 9) == 0);
	endfunction

	task automatic queue_frame(frame_t f);
		frame_queue.push_back(f);
		sent_total++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		case (idx)
			CFG_LOOP:     loop_r = val & 64'hFFFFFF;
			CFG_BAR:      bar_r = val & 64'hFFFFFF;
			CFG_BEAT:     beat_r = val & 64'hFFFFFF;
			CFG_QUANTUM:  quant_r = val & 64'hFFFFFF;
			CFG_OUT_GAIN: og_r = val & 64'hFFFF;
			CFG_IN_GAIN:  ig_r = val & 64'hFFFF;
			CFG_OPTIONS:  opt_r = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_regs(longint lp, longint br, longint bt, longint qt,
		longint og, longint ig, longint opt);
		write_reg(CFG_LOOP, lp);
		write_reg(CFG_BAR, br);
		write_reg(CFG_BEAT, bt);
		write_reg(CFG_QUANTUM, qt);
		write_reg(CFG_OUT_GAIN, og);
		write_reg(CFG_IN_GAIN, ig);
		write_reg(CFG_OPTIONS, opt);
	endtask

	task automatic settle();
		while (taken_total != sent_total || due_outputs.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic report_miss(string what, longint got, longint want);
		if (fails < PRINT_CAP)
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	// input side: predict on every accepted item
	always @(posedge clk) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				due_outputs.push_back(master_step(cur_frame));
				taken_total++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (frame_queue.size() > 0) begin
				cur_frame = frame_queue.pop_front();
				program_left <= cur_frame.pl;
				program_right <= cur_frame.pr;
				line_left <= cur_frame.ll;
				line_right <= cur_frame.lr;
				transport_run <= cur_frame.run;
				rewind_request <= cur_frame.rew;
				buffer_start <= cur_frame.bst;
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: one long hold-off mid run, otherwise random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= 300) begin
			out_ready <= 1'b0;
			hold_left = 200;
			hold_done = 1;
		end else if (ready_gap > 0) begin
			out_ready <= 1'b0;
			ready_gap--;
		end else begin
			out_ready <= 1'b1;
			ready_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		mix_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (due_outputs.size() == 0) begin
				report_miss("item with none pending", out_left, 0);
			end else begin
				want = due_outputs.pop_front();
				if (out_left !== want.left)
					report_miss("out_left", out_left, want.left);
				if (out_right !== want.right)
					report_miss("out_right", out_right, want.right);
				if (peak_out !== want.pk_out)
					report_miss("peak_out", peak_out, want.pk_out);
				if (peak_in !== want.pk_in)
					report_miss("peak_in", peak_in, want.pk_in);
				if (quantum_point !== want.qp)
					report_miss("quantum_point", quantum_point, want.qp);
				if (bar_point !== want.bp)
					report_miss("bar_point", bar_point, want.bp);
				if (loop_zero !== want.lz)
					report_miss("loop_zero", loop_zero, want.lz);
				if (beat_index !== want.beat)
					report_miss("beat_index", beat_index, want.beat);
				if (frame_position !== want.pos)
					report_miss("frame_position", frame_position, want.pos);
			end
		end
	end

	initial begin
		int n;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers, rewind left pending with the grid off
		calm = 1;
		queue_frame(frame_of(S_MAX, S_MIN, S_MAX, S_MIN, 1, 1, 1));
		queue_frame(frame_of('0, '0, '0, '0, 0, 0, 0));
		queue_frame(frame_of(S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 0));
		settle();

		// short loop, smallest periods, full gains, every option on
		set_regs(2, 1, 1, 1, 65535, 65535, 7);
		queue_frame(frame_of('0, '0, '0, '0, 1, 0, 0));
		queue_frame(frame_of(S_MAX, S_MAX, S_MAX, S_MAX, 1, 0, 0));
		queue_frame(frame_of(S_MIN, S_MIN, S_MIN, S_MIN, 1, 0, 0));
		queue_frame(frame_of('0, '0, 24'sd1000, '0, 0, 0, 0));
		queue_frame(frame_of('0, '0, '0, '0, 1, 1, 0));
		queue_frame(frame_of(24'sd100, -24'sd100, 24'sd5, -24'sd5, 1, 0, 1));
		for (int k = 0; k < 4; k++)
			queue_frame(frame_of('0, '0, '0, '0, 1, 0, 0));
		settle();

		set_regs(9, 4, 2, 3, 16384, 8192, 5);
		for (int k = 0; k < 10; k++)
			queue_frame(frame_of(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
				k != 7, k == 4, k == 0));
		settle();

		// zero output gain, monitor off
		set_regs(9, 4, 2, 0, 0, 65535, 0);
		queue_frame(frame_of(S_MAX, S_MIN, S_MAX, S_MIN, 1, 0, 0));
		queue_frame(frame_of(S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 1));
		settle();

		for (int p = 0; p < 9; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (p == 4) begin
				// long run with beat every frame, beat count saturates
				calm = 0;
				set_regs(FRAME_TOP, FRAME_TOP, 1, 0, pick_gain(), pick_gain(),
					$urandom_range(0, 7));
				n = 300;
			end else begin
				set_regs(pick_span(2, 48), pick_span(1, 16), pick_span(1, 8),
					($urandom_range(0, 3) == 0) ? 0 : pick_span(1, 8),
					pick_gain(), pick_gain(), $urandom_range(0, 7));
				n = 50;
			end
			for (int k = 0; k < n; k++)
				queue_frame(random_frame(p == 4));
			settle();
		end

		repeat (20) @(posedge clk);
		if (fails == 0 && due_outputs.size() == 0) begin
			$display("loop_transport_metronome_master_top regression: pass");
		end else begin
			$display("loop_transport_metronome_master_top regression: fail");
		end
		$finish;
	end

endmodule
